// ===== hdl/lwts_pkg.sv =====
// ----------------------------------------------------------------------------
// lwts_pkg: shared types and constants
// Item, result and job formats, the register map and the fixed field widths
// of the longest window with target sum block.
// ----------------------------------------------------------------------------
package lwts_pkg;

	localparam int VALUE_BITS = 16;
	localparam int TARGET_BITS = 26;
	localparam int BEST_BITS = 11;
	// The window sum never exceeds the target by more than one element.
	localparam int SUM_BITS = ((TARGET_BITS > VALUE_BITS) ? TARGET_BITS : VALUE_BITS) + 1;

	localparam int DEFAULT_MAX_LENGTH = 1024;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_INDEX_BITS = APB_ADDR_BITS - 2;
	localparam logic [REG_INDEX_BITS-1:0] REG_TARGET_SUM = REG_INDEX_BITS'(0);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value_in;
		logic                  last_in;
	} in_item_t;

	typedef struct packed {
		logic [BEST_BITS-1:0] best_length;
		logic                 last_out;
		logic                 overflow;
	} out_item_t;

	// One classified element on its way from the front to the back end.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
		logic                  ignore;
	} job_t;

endpackage

// ===== hdl/lwts_front.sv =====
// ----------------------------------------------------------------------------
// lwts_front: input acceptance and classification
// Counts the elements of the current array and marks every element beyond
// the window store length as one to be ignored.
// ----------------------------------------------------------------------------
module lwts_front #(
	parameter int MAX_LENGTH = lwts_pkg::DEFAULT_MAX_LENGTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lwts_pkg::in_item_t item,
	input  logic              q_full,
	output logic              q_push,
	output lwts_pkg::job_t    job
);

	localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_LENGTH);

	logic [CNT_BITS-1:0] elem_q;
	logic                accept;
	logic                ignore;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;
	assign ignore = (elem_q == CNT_MAX);

	assign job.value  = item.value_in;
	assign job.last   = item.last_in;
	assign job.ignore = ignore;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
		end else if (accept) begin
			if (item.last_in) begin
				elem_q <= '0;
			end else if (!ignore) begin
				elem_q <= elem_q + CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== hdl/lwts_queue.sv =====
// ----------------------------------------------------------------------------
// lwts_queue: job queue between front and back end
// A short first-in first-out queue of classified elements.
// ----------------------------------------------------------------------------
module lwts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lwts_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output lwts_pkg::job_t rd_job,
	output logic           empty
);

	lwts_pkg::job_t                  slot_q [lwts_pkg::QUEUE_DEPTH];
	logic [lwts_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [lwts_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [lwts_pkg::QCNT_BITS-1:0]  cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full    = (cnt_q == lwts_pkg::QCNT_BITS'(lwts_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + lwts_pkg::QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + lwts_pkg::QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + lwts_pkg::QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - lwts_pkg::QCNT_BITS'(1);
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job pushed into a full queue");

endmodule

// ===== hdl/lwts_back.sv =====
// ----------------------------------------------------------------------------
// lwts_back: window engine
// Keeps the window in a memory with its running sum, drops the oldest
// elements while the sum is above the target, tracks the best length and
// holds one finished result for the output side.
// ----------------------------------------------------------------------------
module lwts_back #(
	parameter int MAX_LENGTH = lwts_pkg::DEFAULT_MAX_LENGTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [lwts_pkg::TARGET_BITS-1:0]  target,
	input  lwts_pkg::job_t                    job,
	input  logic                              job_empty,
	output logic                              job_pop,
	output lwts_pkg::out_item_t               result,
	output logic                              result_valid,
	input  logic                              result_pop
);

	localparam int PTR_BITS = $clog2(MAX_LENGTH);
	localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(MAX_LENGTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_LENGTH);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SHRINK = 2'b10
	} state_t;

	function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_BITS'(1);
	endfunction

	logic [lwts_pkg::VALUE_BITS-1:0] store_mem [MAX_LENGTH];

	state_t                           state_q;
	logic [PTR_BITS-1:0]              head_q;
	logic [PTR_BITS-1:0]              tail_q;
	logic [CNT_BITS-1:0]              count_q;
	logic [lwts_pkg::SUM_BITS-1:0]    sum_q;
	logic [CNT_BITS-1:0]              best_q;
	logic                             ovf_q;
	logic                             last_q;
	logic                             byp_q;
	logic                             out_valid_q;
	logic [lwts_pkg::VALUE_BITS-1:0]  val_q;
	logic [lwts_pkg::VALUE_BITS-1:0]  rd_q;
	lwts_pkg::out_item_t              out_q;

	logic [lwts_pkg::SUM_BITS-1:0]    target_ext;
	logic [lwts_pkg::VALUE_BITS-1:0]  head_val;
	logic [CNT_BITS-1:0]              best_new;
	logic [PTR_BITS-1:0]              rd_addr;
	logic                             out_free;
	logic                             pop_win;
	logic                             mem_we;
	logic                             emit;
	logic [CNT_BITS-1:0]              emit_best;
	logic                             emit_last;
	logic                             emit_ovf;

	assign target_ext   = lwts_pkg::SUM_BITS'(target);
	// The oldest element is the one just written when the window was empty.
	assign head_val     = byp_q ? val_q : rd_q;
	assign out_free     = !out_valid_q || result_pop;
	assign pop_win      = (state_q == ST_SHRINK) && (sum_q > target_ext) && (count_q != '0);
	assign best_new     = ((sum_q == target_ext) && (count_q > best_q)) ? count_q : best_q;
	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_comb begin
		job_pop   = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = head_q;
		emit      = 1'b0;
		emit_best = best_q;
		emit_last = 1'b0;
		emit_ovf  = ovf_q;
		case (state_q)
			ST_IDLE: begin
				if (!job_empty) begin
					if (job.ignore) begin
						if (out_free) begin
							job_pop   = 1'b1;
							emit      = 1'b1;
							emit_ovf  = 1'b1;
							emit_last = job.last;
						end
					end else begin
						job_pop = 1'b1;
						mem_we  = 1'b1;
					end
				end
			end
			ST_SHRINK: begin
				if (pop_win) begin
					// Fetch the next oldest element for the following cycle.
					rd_addr = advance(head_q);
				end else if (out_free) begin
					emit      = 1'b1;
					emit_best = best_new;
					emit_last = last_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[tail_q] <= job.value;
		end
		rd_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_q <= job.value;
		end
		if (emit) begin
			out_q.best_length <= lwts_pkg::BEST_BITS'(emit_best);
			out_q.last_out    <= emit_last;
			out_q.overflow    <= emit_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (mem_we) begin
						tail_q  <= advance(tail_q);
						count_q <= count_q + CNT_BITS'(1);
						sum_q   <= sum_q + lwts_pkg::SUM_BITS'(job.value);
						byp_q   <= (count_q == '0);
						last_q  <= job.last;
						state_q <= ST_SHRINK;
					end
					if (emit && !emit_last) begin
						ovf_q <= 1'b1;
					end
				end
				ST_SHRINK: begin
					if (pop_win) begin
						sum_q   <= sum_q - lwts_pkg::SUM_BITS'(head_val);
						head_q  <= advance(head_q);
						count_q <= count_q - CNT_BITS'(1);
						byp_q   <= 1'b0;
					end else if (emit) begin
						if (!emit_last) begin
							best_q <= best_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// The end of an array clears the window as its result is written to the output register.
			if (emit && emit_last) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
				sum_q   <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("window count exceeds the store length");

	a_empty_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty window with head and tail apart");

	a_bypass_single: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SHRINK) && byp_q) |-> (count_q == CNT_BITS'(1)))
		else $error("bypassed head value used with more than one element");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_pop) |-> !emit)
		else $error("result written over one that was not transferred");

endmodule

// ===== hdl/longest_window_with_target_sum.sv =====
// ----------------------------------------------------------------------------
// longest_window_with_target_sum: longest window with a target sum
// Streams array elements through a sliding window and reports, for every
// element, the longest window so far whose sum equals the target.
//
//   Channel   Signals                               Transfer when
//   item      push, full, item                      push && !full
//   result    empty, pop, result                    pop && !empty
//   config    psel, penable, pwrite, paddr,         psel && penable && pwrite
//             pwdata, prdata, pready
//
// The window engine stores an element, drops elements from the front one
// after another through the store's single read port while the sum is above
// the target, then emits the result. An element past the store length goes
// straight out as an overflow result. Reset clears all control state at once;
// the window store is not cleared. A four-entry job queue and a one-result
// output register let the input and output sides stall on their own.
// ----------------------------------------------------------------------------
module longest_window_with_target_sum #(
	parameter int MAX_LENGTH = lwts_pkg::DEFAULT_MAX_LENGTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  lwts_pkg::in_item_t                  item,
	output logic                                empty,
	input  logic                                pop,
	output lwts_pkg::out_item_t                 result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lwts_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [lwts_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [lwts_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready
);

	logic [lwts_pkg::TARGET_BITS-1:0]    target_q;
	logic [lwts_pkg::REG_INDEX_BITS-1:0] reg_index;
	logic                                q_full;
	logic                                q_push;
	logic                                q_empty;
	logic                                q_pop;
	logic                                result_valid;
	lwts_pkg::job_t                      front_job;
	lwts_pkg::job_t                      back_job;

	assign pready    = 1'b1;
	assign reg_index = paddr[lwts_pkg::APB_ADDR_BITS-1:2];
	assign empty     = !result_valid;

	always_comb begin
		if (reg_index == lwts_pkg::REG_TARGET_SUM) begin
			prdata = lwts_pkg::APB_DATA_BITS'(target_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (reg_index == lwts_pkg::REG_TARGET_SUM)) begin
			target_q <= pwdata[lwts_pkg::TARGET_BITS-1:0];
		end
	end

	lwts_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.job    (front_job)
	);

	lwts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (front_job),
		.full   (q_full),
		.pop    (q_pop),
		.rd_job (back_job),
		.empty  (q_empty)
	);

	lwts_back #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.target       (target_q),
		.job          (back_job),
		.job_empty    (q_empty),
		.job_pop      (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_pop   (pop)
	);

endmodule
